FILE: rtl/msv_pkg.sv
// Shared types, constants and arithmetic helpers of the synth voice.
`timescale 1ns / 1ps

package msv_pkg;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 60;
    localparam int DIV_N_W = 31;
    localparam int DIV_D_W = 32;
    localparam int DIV_Q_W = 22;

    localparam logic [16:0]        ONE_Q16       = 17'd65536;
    localparam logic [23:0]        ENV_ONE       = 24'd8388608;
    localparam logic signed [24:0] DECAY_EPS     = 25'sd8389;
    localparam logic [23:0]        RELEASE_FLOOR = 24'd839;
    localparam logic [24:0]        OUT_GAIN      = 25'd45875;
    localparam logic [24:0]        DRIVE_BASE    = 25'd4096;
    localparam logic [31:0]        CLIP_ONE      = 32'd4194304;
    localparam logic signed [24:0] RAMP_OFFSET   = 25'sd4194304;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;

    // Frequencies of the top octave (notes 120 to 131) in Hz, Q16.
    localparam logic [31:0] TOP_OCT_HZ_Q16 [12] = '{
        32'd548668578, 32'd581294109, 32'd615859655, 32'd652480575,
        32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
        32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
    };

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic [15:0] osc_blend;
        logic [15:0] drive_amount;
        logic [15:0] filter_alpha;
        logic [15:0] filter_feedback;
        logic [23:0] attack_step;
        logic [16:0] decay_coeff;
        logic [23:0] sustain_level;
        logic [15:0] release_coeff;
    } cfg_t;

    // Signed shift right with round to nearest, ties away from zero.
    function automatic acc_t shr_round(input acc_t v, input int s);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        r = (mag + (ACC_W'(1) << (s - 1))) >> s;
        return v[ACC_W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [23:0] sat24(input acc_t v);
        if (v > 60'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -60'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    // Sine of a 32-bit phase fraction, Q1.22, by a Taylor series in Q30.
    function automatic logic signed [23:0] sine_from_c(input logic [63:0] c);
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        quad = c[31:30];
        r = {34'd0, c[29:0]};
        if (quad[0]) begin
            r = Q30_ONE - r;
        end
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (((x * t) >> 30) + 64'd128) >> 8;
        return quad[1] ? -$signed(s[23:0]) : $signed(s[23:0]);
    endfunction

endpackage

FILE: rtl/mono_synth_voice.sv
// Top level of the monophonic synth voice: sequencer, voice state and ROMs.
`timescale 1ns / 1ps
//
//  Channel   Ports                         Carries
//  --------  ----------------------------  -----------------------------------------
//  input     s_tvalid/s_tready/s_tdata/    one request: tick, note on or note off
//            s_tuser
//  result    m_tvalid/m_tready/m_tdata/    one audio sample and the active flag per tick
//            m_tuser
//  config    cfg_valid/cfg_ready/          register index and write data
//            cfg_index/cfg_data
//
//  A note-on or note-off request is handled in ST_IDLE. A sample tick on an
//  active voice runs the chain of steps through the one shared multiplier,
//  with ST_ENV_2 added in decay or release; with a nonzero drive the soft-clip
//  divider is added as well. A tick on an idle voice goes straight to ST_DONE.
//  Reset is synchronous and active low and needs no clearing pass. A finished
//  tick waits in its last step while the result register still holds an
//  unaccepted sample, and no request is taken then; once the sample moves into
//  that register, intake resumes even if the result side keeps stalling.

module mono_synth_voice #(
    parameter int SAMPLE_RATE      = 48000,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [6:0] note_number, [23:7] glide_coeff
    input  logic [1:0]  s_tuser,    // [1:0] req_type
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [23:0] sample_out
    output logic [0:0]  m_tuser,    // [0] voice_active
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

    // The sequencer walks one step per cycle but holds in ST_DIV_WAIT and ST_DONE. Each
    // step that loads the multiplier is followed by one that consumes its product.
    typedef enum logic [23:0] {
        ST_IDLE     = 24'h000001,
        ST_GLD_MUL  = 24'h000002,
        ST_GLD_UPD  = 24'h000004,
        ST_PH_ADD   = 24'h000008,
        ST_IDX_MUL  = 24'h000010,
        ST_SIN_RD   = 24'h000020,
        ST_BL_MUL0  = 24'h000040,
        ST_BL_MUL1  = 24'h000080,
        ST_BL_SUM   = 24'h000100,
        ST_ENV_1    = 24'h000200,
        ST_ENV_2    = 24'h000400,
        ST_ENV_MUL  = 24'h000800,
        ST_ENV_SCL  = 24'h001000,
        ST_DRV_MUL  = 24'h002000,
        ST_DRV_DIV  = 24'h004000,
        ST_DIV_WAIT = 24'h008000,
        ST_FB_MUL   = 24'h010000,
        ST_FB_SUB   = 24'h020000,
        ST_LP_MUL0  = 24'h040000,
        ST_LP_MUL1  = 24'h080000,
        ST_LP_SUM   = 24'h100000,
        ST_OG_MUL   = 24'h200000,
        ST_OG_RND   = 24'h400000,
        ST_DONE     = 24'h800000
    } state_t;

    typedef enum logic [4:0] {
        ENV_IDLE    = 5'b00001,
        ENV_ATTACK  = 5'b00010,
        ENV_DECAY   = 5'b00100,
        ENV_SUSTAIN = 5'b01000,
        ENV_RELEASE = 5'b10000
    } env_t;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_ON   = 2'd1,
        REQ_OFF  = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    // Configuration registers.
    msv_pkg::cfg_t cfg;

    assign cfg_ready = 1'b1;

    msv_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Sine ROM, one full cycle in Q1.22, built at elaboration.
    logic signed [23:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
        localparam logic [63:0] PH = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
        assign sine_rom[k] = msv_pkg::sine_from_c(PH);
    end

    // Note to phase increment ROM: the top octave shifted down one bit per
    // octave, then scaled by 256 / SAMPLE_RATE with rounding.
    logic [31:0] note_inc [128];

    for (genvar n = 0; n < 128; n++) begin : g_note
        localparam logic [63:0] FREQ =
            64'(msv_pkg::TOP_OCT_HZ_Q16[n % 12] >> (10 - n / 12));
        localparam logic [63:0] INC =
            (FREQ * 64'd256 + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
        assign note_inc[n] = INC[31:0];
    end

    // Shared multiplier and soft-clip divider.
    logic signed [msv_pkg::MUL_A_W-1:0] mul_a;
    logic signed [msv_pkg::MUL_B_W-1:0] mul_b;
    logic signed [msv_pkg::MUL_P_W-1:0] mul_p;
    logic                               div_start;
    logic [msv_pkg::DIV_N_W-1:0]        div_num;
    logic [msv_pkg::DIV_D_W-1:0]        div_den;
    logic                               div_done;
    logic [msv_pkg::DIV_Q_W-1:0]        div_quot;

    msv_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    msv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Control state.
    state_t state_reg, state_next;
    env_t   env_stage_reg, env_stage_next;
    logic   m_valid_reg, m_valid_next;

    // Voice state.
    logic [23:0]        env_level_reg, env_level_next;
    logic [23:0]        phase_reg, phase_next;
    logic [31:0]        cur_inc_reg, cur_inc_next;
    logic [31:0]        tgt_inc_reg, tgt_inc_next;
    logic [16:0]        glide_reg, glide_next;
    logic signed [23:0] fmem_reg, fmem_next;

    // Working registers of one tick.
    logic                 dir_reg, dir_next;
    logic                 neg_reg, neg_next;
    logic signed [23:0]   sine_reg, sine_next;
    logic signed [31:0]   osc_reg, osc_next;
    msv_pkg::acc_t        acc_reg, acc_next;
    logic signed [23:0]   res_data_reg, res_data_next;
    logic                 res_active_reg, res_active_next;
    logic [23:0]          out_data_reg;
    logic                 out_active_reg;
    logic                 out_load;

    logic [1:0]  in_req;
    logic [6:0]  in_note;
    logic [16:0] in_glide;

    assign in_req   = s_tuser;
    assign in_note  = s_tdata[6:0];
    assign in_glide = s_tdata[23:7];
    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        logic [16:0]         g_sat;
        logic [31:0]         gmag;
        logic [32:0]         gstep;
        logic [24:0]         lvl_sum;
        logic [24:0]         dstep;
        logic [23:0]         dlvl;
        logic signed [24:0]  dd;
        logic signed [24:0]  ramp;
        msv_pkg::acc_t       rnd;
        logic [29:0]         xmag;

        state_next      = state_reg;
        env_stage_next  = env_stage_reg;
        env_level_next  = env_level_reg;
        phase_next      = phase_reg;
        cur_inc_next    = cur_inc_reg;
        tgt_inc_next    = tgt_inc_reg;
        glide_next      = glide_reg;
        fmem_next       = fmem_reg;
        dir_next        = dir_reg;
        neg_next        = neg_reg;
        sine_next       = sine_reg;
        osc_next        = osc_reg;
        acc_next        = acc_reg;
        res_data_next   = res_data_reg;
        res_active_next = res_active_reg;
        mul_a           = '0;
        mul_b           = '0;
        div_start       = 1'b0;
        div_num         = '0;
        div_den         = '0;

        g_sat   = (in_glide > msv_pkg::ONE_Q16) ? msv_pkg::ONE_Q16 : in_glide;
        gmag    = dir_reg ? (tgt_inc_reg - cur_inc_reg) : (cur_inc_reg - tgt_inc_reg);
        gstep   = 33'((mul_p[48:0] + 49'd65535) >> 16);
        lvl_sum = {1'b0, env_level_reg} + {1'b0, cfg.attack_step};
        dstep   = 25'((mul_p[40:0] + 41'd65535) >> 16);
        dlvl    = dir_reg ? (env_level_reg + dstep[23:0]) : (env_level_reg - dstep[23:0]);
        dd      = $signed({1'b0, dlvl}) - $signed({1'b0, cfg.sustain_level});
        ramp    = $signed({2'b00, phase_reg[23:1]}) - msv_pkg::RAMP_OFFSET;
        rnd     = '0;
        xmag    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (req_t'(in_req))
                        REQ_ON: begin
                            tgt_inc_next = note_inc[in_note];
                            if (env_stage_reg == ENV_IDLE || g_sat == msv_pkg::ONE_Q16) begin
                                cur_inc_next = note_inc[in_note];
                            end
                            glide_next     = g_sat;
                            env_stage_next = ENV_ATTACK;
                        end
                        REQ_OFF: begin
                            if (env_stage_reg != ENV_IDLE) begin
                                env_stage_next = ENV_RELEASE;
                            end
                        end
                        REQ_TICK: begin
                            if (env_stage_reg == ENV_IDLE) begin
                                res_data_next   = '0;
                                res_active_next = 1'b0;
                                state_next      = ST_DONE;
                            end else begin
                                dir_next   = tgt_inc_reg >= cur_inc_reg;
                                state_next = ST_GLD_MUL;
                            end
                        end
                        REQ_NONE: ;
                        default: ;
                    endcase
                end
            end
            // Glide: the step toward the target is rounded up in magnitude.
            ST_GLD_MUL: begin
                mul_a      = {1'b0, gmag};
                mul_b      = {8'd0, glide_reg};
                state_next = ST_GLD_UPD;
            end
            ST_GLD_UPD: begin
                cur_inc_next = dir_reg ? (cur_inc_reg + gstep[31:0])
                                       : (cur_inc_reg - gstep[31:0]);
                state_next   = ST_PH_ADD;
            end
            ST_PH_ADD: begin
                phase_next = phase_reg + cur_inc_reg[23:0];
                state_next = ST_IDX_MUL;
            end
            ST_IDX_MUL: begin
                mul_a      = {9'd0, phase_reg};
                mul_b      = msv_pkg::MUL_B_W'(SINE_TABLE_DEPTH);
                state_next = ST_SIN_RD;
            end
            ST_SIN_RD: begin
                sine_next  = sine_rom[mul_p[24 +: IDX_W]];
                state_next = ST_BL_MUL0;
            end
            // Blend of sine and ramp, accumulated over two products.
            ST_BL_MUL0: begin
                mul_a      = msv_pkg::MUL_A_W'(sine_reg);
                mul_b      = {8'd0, 17'(msv_pkg::ONE_Q16 - {1'b0, cfg.osc_blend})};
                state_next = ST_BL_MUL1;
            end
            ST_BL_MUL1: begin
                acc_next   = msv_pkg::ACC_W'(mul_p);
                mul_a      = msv_pkg::MUL_A_W'(ramp);
                mul_b      = {9'd0, cfg.osc_blend};
                state_next = ST_BL_SUM;
            end
            ST_BL_SUM: begin
                rnd        = msv_pkg::shr_round(acc_reg + msv_pkg::ACC_W'(mul_p), 16);
                osc_next   = rnd[31:0];
                state_next = ST_ENV_1;
            end
            // Envelope: attack and sustain finish here, decay and release
            // need one product first.
            ST_ENV_1: begin
                unique case (env_stage_reg)
                    ENV_ATTACK: begin
                        if (lvl_sum >= {1'b0, msv_pkg::ENV_ONE}) begin
                            env_level_next = msv_pkg::ENV_ONE;
                            env_stage_next = ENV_DECAY;
                        end else begin
                            env_level_next = lvl_sum[23:0];
                        end
                        state_next = ST_ENV_MUL;
                    end
                    ENV_DECAY: begin
                        dir_next   = cfg.sustain_level >= env_level_reg;
                        mul_a      = {9'd0, (cfg.sustain_level >= env_level_reg) ?
                                     (cfg.sustain_level - env_level_reg) :
                                     (env_level_reg - cfg.sustain_level)};
                        mul_b      = {8'd0, cfg.decay_coeff};
                        state_next = ST_ENV_2;
                    end
                    ENV_SUSTAIN: begin
                        env_level_next = cfg.sustain_level;
                        state_next     = ST_ENV_MUL;
                    end
                    ENV_RELEASE: begin
                        mul_a      = {9'd0, env_level_reg};
                        mul_b      = {9'd0, cfg.release_coeff};
                        state_next = ST_ENV_2;
                    end
                    default: begin
                        env_stage_next = ENV_IDLE;
                        env_level_next = '0;
                        state_next     = ST_ENV_MUL;
                    end
                endcase
            end
            ST_ENV_2: begin
                if (env_stage_reg == ENV_DECAY) begin
                    if (dd > -msv_pkg::DECAY_EPS && dd < msv_pkg::DECAY_EPS) begin
                        env_level_next = cfg.sustain_level;
                        env_stage_next = ENV_SUSTAIN;
                    end else begin
                        env_level_next = dlvl;
                    end
                end else begin
                    if (mul_p[39:16] < msv_pkg::RELEASE_FLOOR) begin
                        env_level_next = '0;
                        env_stage_next = ENV_IDLE;
                    end else begin
                        env_level_next = mul_p[39:16];
                    end
                end
                state_next = ST_ENV_MUL;
            end
            ST_ENV_MUL: begin
                mul_a      = msv_pkg::MUL_A_W'(osc_reg);
                mul_b      = {1'b0, env_level_reg};
                state_next = ST_ENV_SCL;
            end
            ST_ENV_SCL: begin
                rnd        = msv_pkg::shr_round(msv_pkg::ACC_W'(mul_p), 23);
                osc_next   = rnd[31:0];
                state_next = (cfg.drive_amount != '0) ? ST_DRV_MUL : ST_FB_MUL;
            end
            // Soft clip x / (1 + |x|) after a gain of 1 + 8 * drive.
            ST_DRV_MUL: begin
                mul_a      = msv_pkg::MUL_A_W'(osc_reg);
                mul_b      = msv_pkg::DRIVE_BASE + {6'd0, cfg.drive_amount, 3'd0};
                state_next = ST_DRV_DIV;
            end
            ST_DRV_DIV: begin
                rnd        = msv_pkg::shr_round(msv_pkg::ACC_W'(mul_p), 12);
                neg_next   = rnd[msv_pkg::ACC_W-1];
                xmag       = rnd[msv_pkg::ACC_W-1] ? 30'(-rnd) : rnd[29:0];
                div_start  = 1'b1;
                div_num    = {1'b0, xmag};
                div_den    = msv_pkg::CLIP_ONE + {2'd0, xmag};
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    osc_next   = neg_reg ? -$signed({10'd0, div_quot})
                                         : $signed({10'd0, div_quot});
                    state_next = ST_FB_MUL;
                end
            end
            // Resonant one-pole lowpass.
            ST_FB_MUL: begin
                mul_a      = msv_pkg::MUL_A_W'(fmem_reg);
                mul_b      = {9'd0, cfg.filter_feedback};
                state_next = ST_FB_SUB;
            end
            ST_FB_SUB: begin
                rnd        = msv_pkg::shr_round(msv_pkg::ACC_W'(mul_p), 12);
                osc_next   = osc_reg - rnd[31:0];
                state_next = ST_LP_MUL0;
            end
            ST_LP_MUL0: begin
                mul_a      = msv_pkg::MUL_A_W'(osc_reg);
                mul_b      = {9'd0, cfg.filter_alpha};
                state_next = ST_LP_MUL1;
            end
            ST_LP_MUL1: begin
                acc_next   = msv_pkg::ACC_W'(mul_p);
                mul_a      = msv_pkg::MUL_A_W'(fmem_reg);
                mul_b      = {8'd0, 17'(msv_pkg::ONE_Q16 - {1'b0, cfg.filter_alpha})};
                state_next = ST_LP_SUM;
            end
            ST_LP_SUM: begin
                rnd        = msv_pkg::shr_round(acc_reg + msv_pkg::ACC_W'(mul_p), 16);
                fmem_next  = msv_pkg::sat24(rnd);
                state_next = ST_OG_MUL;
            end
            ST_OG_MUL: begin
                mul_a      = msv_pkg::MUL_A_W'(fmem_reg);
                mul_b      = msv_pkg::OUT_GAIN;
                state_next = ST_OG_RND;
            end
            ST_OG_RND: begin
                rnd             = msv_pkg::shr_round(msv_pkg::ACC_W'(mul_p), 16);
                res_data_next   = msv_pkg::sat24(rnd);
                res_active_next = (env_stage_reg != ENV_IDLE);
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            env_stage_reg <= ENV_IDLE;
            m_valid_reg   <= 1'b0;
            env_level_reg <= '0;
            phase_reg     <= '0;
            cur_inc_reg   <= '0;
            tgt_inc_reg   <= '0;
            glide_reg     <= msv_pkg::ONE_Q16;
            fmem_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            env_stage_reg <= env_stage_next;
            m_valid_reg   <= m_valid_next;
            env_level_reg <= env_level_next;
            phase_reg     <= phase_next;
            cur_inc_reg   <= cur_inc_next;
            tgt_inc_reg   <= tgt_inc_next;
            glide_reg     <= glide_next;
            fmem_reg      <= fmem_next;
        end
    end

    always_ff @(posedge aclk) begin
        dir_reg        <= dir_next;
        neg_reg        <= neg_next;
        sine_reg       <= sine_next;
        osc_reg        <= osc_next;
        acc_reg        <= acc_next;
        res_data_reg   <= res_data_next;
        res_active_reg <= res_active_next;
        if (out_load) begin
            out_data_reg   <= res_data_reg;
            out_active_reg <= res_active_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_active_reg;

    // The sequencer holds exactly one step at a time.
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    // The envelope never climbs above unity.
    a_env_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        env_level_reg <= msv_pkg::ENV_ONE)
        else $error("envelope level above unity");

    // An idle voice has a silent envelope.
    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        env_stage_reg == ENV_IDLE |-> env_level_reg == '0)
        else $error("idle voice with nonzero envelope");

    // The divider only finishes while the sequencer waits for it.
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside its wait step");

endmodule

FILE: rtl/msv_cfg.sv
// Configuration register file of the synth voice, with write-time saturation.
`timescale 1ns / 1ps

module msv_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [2:0]    wr_index,
    input  logic [23:0]   wr_data,
    output msv_pkg::cfg_t cfg
);

    typedef enum logic [2:0] {
        REG_OSC_BLEND       = 3'd0,
        REG_DRIVE_AMOUNT    = 3'd1,
        REG_FILTER_ALPHA    = 3'd2,
        REG_FILTER_FEEDBACK = 3'd3,
        REG_ATTACK_STEP     = 3'd4,
        REG_DECAY_COEFF     = 3'd5,
        REG_SUSTAIN_LEVEL   = 3'd6,
        REG_RELEASE_COEFF   = 3'd7
    } reg_index_t;

    msv_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.osc_blend       <= '0;
            cfg_reg.drive_amount    <= '0;
            cfg_reg.filter_alpha    <= 16'hFFFF;
            cfg_reg.filter_feedback <= '0;
            cfg_reg.attack_step     <= msv_pkg::ENV_ONE;
            cfg_reg.decay_coeff     <= msv_pkg::ONE_Q16;
            cfg_reg.sustain_level   <= msv_pkg::ENV_ONE;
            cfg_reg.release_coeff   <= '0;
        end else if (wr_en) begin
            unique case (reg_index_t'(wr_index))
                REG_OSC_BLEND:       cfg_reg.osc_blend       <= wr_data[15:0];
                REG_DRIVE_AMOUNT:    cfg_reg.drive_amount    <= wr_data[15:0];
                REG_FILTER_ALPHA:    cfg_reg.filter_alpha    <= wr_data[15:0];
                REG_FILTER_FEEDBACK: cfg_reg.filter_feedback <= wr_data[15:0];
                REG_ATTACK_STEP:     cfg_reg.attack_step     <= wr_data;
                REG_DECAY_COEFF: begin
                    cfg_reg.decay_coeff <= (wr_data[16:0] > msv_pkg::ONE_Q16) ?
                                           msv_pkg::ONE_Q16 : wr_data[16:0];
                end
                REG_SUSTAIN_LEVEL: begin
                    cfg_reg.sustain_level <= (wr_data > msv_pkg::ENV_ONE) ?
                                             msv_pkg::ENV_ONE : wr_data;
                end
                REG_RELEASE_COEFF:   cfg_reg.release_coeff   <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/msv_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module msv_mul (
    input  logic                                 aclk,
    input  logic signed [msv_pkg::MUL_A_W-1:0]   a,
    input  logic signed [msv_pkg::MUL_B_W-1:0]   b,
    output logic signed [msv_pkg::MUL_P_W-1:0]   p
);

    logic signed [msv_pkg::MUL_P_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

FILE: rtl/msv_div.sv
// Radix-2 restoring divider for the soft clip, one quotient bit per cycle.
`timescale 1ns / 1ps

module msv_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [msv_pkg::DIV_N_W-1:0]    num,
    input  logic [msv_pkg::DIV_D_W-1:0]    den,
    output logic                           done,
    output logic [msv_pkg::DIV_Q_W-1:0]    quot
);

    // The dividend is num shifted left by DIV_Q_W zero bits; num < den, so
    // the quotient fits in DIV_Q_W bits and num is the starting remainder.
    localparam int CNT_W = $clog2(msv_pkg::DIV_Q_W + 1);

    logic                          busy_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [msv_pkg::DIV_D_W-1:0]   rem_reg;
    logic [msv_pkg::DIV_D_W-1:0]   den_reg;
    logic [msv_pkg::DIV_Q_W-1:0]   quot_reg;
    logic [msv_pkg::DIV_D_W:0]     rem_shift;
    logic [msv_pkg::DIV_D_W:0]     rem_diff;
    logic                          fits;

    always_comb begin
        rem_shift = {rem_reg, 1'b0};
        rem_diff  = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(msv_pkg::DIV_Q_W);
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end else begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= msv_pkg::DIV_D_W'(num);
            den_reg  <= den;
            quot_reg <= '0;
        end else if (busy_reg && cnt_reg != '0) begin
            rem_reg  <= fits ? rem_diff[msv_pkg::DIV_D_W-1:0]
                             : rem_shift[msv_pkg::DIV_D_W-1:0];
            quot_reg <= {quot_reg[msv_pkg::DIV_Q_W-2:0], fits};
        end
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign quot = quot_reg;

endmodule

FILE: dv/msv_tb_pkg.sv
// Request kinds and register indexes shared by the synth voice testbench files.
`timescale 1ns / 1ps

package msv_tb_pkg;

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_NOTE_ON  = 2'd1,
        REQ_NOTE_OFF = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        REG_OSC_BLEND       = 3'd0,
        REG_DRIVE_AMOUNT    = 3'd1,
        REG_FILTER_ALPHA    = 3'd2,
        REG_FILTER_FEEDBACK = 3'd3,
        REG_ATTACK_STEP     = 3'd4,
        REG_DECAY_COEFF     = 3'd5,
        REG_SUSTAIN_LEVEL   = 3'd6,
        REG_RELEASE_COEFF   = 3'd7
    } reg_index_t;

endpackage

FILE: dv/msv_checker.sv
// Predicts each synth voice sample from the observed requests and compares the results.
`timescale 1ns / 1ps

module msv_checker #(
    parameter int SAMPLE_RATE      = 48000,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          error_count,
    output int          pending_count
);

    typedef enum logic [2:0] {
        ENV_IDLE, ENV_ATTACK, ENV_DECAY, ENV_SUSTAIN, ENV_RELEASE
    } env_stage_t;

    typedef struct {
        logic [23:0] sample;
        logic        active;
    } voice_out_t;

    localparam longint unsigned Q30 = 64'd1073741824;
    localparam longint unsigned HALF_PI = 64'd1686629713;
    localparam longint ENV_FULL = 8388608;

    const logic [31:0] top_octave [12] = '{
        32'd548668578, 32'd581294109, 32'd615859655, 32'd652480575,
        32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
        32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
    };

    longint sine_lut [SINE_TABLE_DEPTH];

    longint blend, drive, alpha, feedback, attack, decay, sustain, release_k;
    env_stage_t stage;
    longint level, phase, cur_inc, tgt_inc, glide, fmem;

    voice_out_t sample_q [$];

    function automatic longint sine_value(int k);
        longint unsigned c, r, x, x2, t, s;
        int unsigned quad;
        c = (longint'(k) << 32) / SINE_TABLE_DEPTH;
        quad = (c >> 30) & 3;
        r = c & (Q30 - 1);
        if (quad & 1) r = Q30 - r;
        x = (r * HALF_PI) >> 30;
        x2 = (x * x) >> 30;
        t = Q30 - x2 / 110;
        t = Q30 - ((x2 * t) >> 30) / 72;
        t = Q30 - ((x2 * t) >> 30) / 42;
        t = Q30 - ((x2 * t) >> 30) / 20;
        t = Q30 - ((x2 * t) >> 30) / 6;
        s = (((x * t) >> 30) + 128) >> 8;
        return (quad >= 2) ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint round_shift(longint v, int sh);
        longint unsigned mag, r;
        mag = (v < 0) ? -v : v;
        r = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // Moves toward the target by coeff/65536 of the gap, rounding the step up.
    function automatic longint step_toward(longint cur, longint tgt, longint coeff);
        longint unsigned step;
        if (tgt >= cur) begin
            step = ((tgt - cur) * coeff + 65535) >> 16;
            return cur + step;
        end
        step = ((cur - tgt) * coeff + 65535) >> 16;
        return cur - step;
    endfunction

    function automatic longint note_to_increment(int note);
        longint f;
        f = top_octave[note % 12] >> (10 - note / 12);
        return (f * 256 + SAMPLE_RATE / 2) / SAMPLE_RATE;
    endfunction

    function automatic voice_out_t render_tick();
        voice_out_t o;
        longint osc, ramp, x, ax, st, u, y, d;
        int idx;
        if (stage == ENV_IDLE) begin
            o.sample = '0;
            o.active = 1'b0;
            return o;
        end
        cur_inc = step_toward(cur_inc, tgt_inc, glide);
        phase = (phase + cur_inc) & 64'hFFFFFF;
        idx = (phase * SINE_TABLE_DEPTH) >> 24;
        if (idx >= SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH - 1;
        ramp = (phase >> 1) - 4194304;
        osc = round_shift(sine_lut[idx] * (65536 - blend) + ramp * blend, 16);
        case (stage)
            ENV_ATTACK: begin
                level = level + attack;
                if (level >= ENV_FULL) begin
                    level = ENV_FULL;
                    stage = ENV_DECAY;
                end
            end
            ENV_DECAY: begin
                level = step_toward(level, sustain, decay);
                d = level - sustain;
                if (d > -8389 && d < 8389) begin
                    level = sustain;
                    stage = ENV_SUSTAIN;
                end
            end
            ENV_SUSTAIN: level = sustain;
            ENV_RELEASE: begin
                level = (level * release_k) >> 16;
                if (level < 839) begin
                    level = 0;
                    stage = ENV_IDLE;
                end
            end
            default: begin
                stage = ENV_IDLE;
                level = 0;
            end
        endcase
        level = level & 64'hFFFFFF;
        osc = round_shift(osc * level, 23);
        if (drive != 0) begin
            x = round_shift(osc * (4096 + 8 * drive), 12);
            ax = (x < 0) ? -x : x;
            osc = (x * 4194304) / (4194304 + ax);
        end
        st = fmem;
        u = osc - round_shift(feedback * st, 12);
        y = round_shift(alpha * u + (65536 - alpha) * st, 16);
        fmem = clamp24(y);
        o.sample = 24'(clamp24(round_shift(fmem * 45875, 16)));
        o.active = (stage != ENV_IDLE);
        return o;
    endfunction

    initial begin
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) sine_lut[k] = sine_value(k);
    end

    always @(posedge aclk) begin
        voice_out_t got, want;
        longint g;
        if (!aresetn) begin
            blend = 0; drive = 0; alpha = 65535; feedback = 0;
            attack = ENV_FULL; decay = 65536; sustain = ENV_FULL; release_k = 0;
            stage = ENV_IDLE; level = 0; phase = 0;
            cur_inc = 0; tgt_inc = 0; glide = 65536; fmem = 0;
            sample_q.delete();
        end else begin
            // Results are checked before this edge's request so a result can never
            // be matched against the request accepted in the same cycle.
            if (m_tvalid && m_tready) begin
                got.sample = m_tdata;
                got.active = m_tuser[0];
                if (sample_q.size() == 0) begin
                    $error("unexpected result: sample_out %0d voice_active %0d",
                           $signed(got.sample), got.active);
                    error_count++;
                end else begin
                    want = sample_q.pop_front();
                    if (got.sample !== want.sample) begin
                        $error("sample_out expected %0d actual %0d",
                               $signed(want.sample), $signed(got.sample));
                        error_count++;
                    end
                    if (got.active !== want.active) begin
                        $error("voice_active expected %0d actual %0d",
                               want.active, got.active);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (msv_tb_pkg::reg_index_t'(cfg_index))
                    msv_tb_pkg::REG_OSC_BLEND:       blend = cfg_data[15:0];
                    msv_tb_pkg::REG_DRIVE_AMOUNT:    drive = cfg_data[15:0];
                    msv_tb_pkg::REG_FILTER_ALPHA:    alpha = cfg_data[15:0];
                    msv_tb_pkg::REG_FILTER_FEEDBACK: feedback = cfg_data[15:0];
                    msv_tb_pkg::REG_ATTACK_STEP:     attack = cfg_data;
                    msv_tb_pkg::REG_DECAY_COEFF:
                        decay = (cfg_data[16:0] > 65536) ? 65536 : cfg_data[16:0];
                    msv_tb_pkg::REG_SUSTAIN_LEVEL:
                        sustain = (cfg_data > ENV_FULL) ? ENV_FULL : cfg_data;
                    default:                         release_k = cfg_data[15:0];
                endcase
            end
            if (s_tvalid && s_tready) begin
                case (msv_tb_pkg::req_kind_t'(s_tuser))
                    msv_tb_pkg::REQ_NOTE_ON: begin
                        g = (s_tdata[23:7] > 65536) ? 65536 : s_tdata[23:7];
                        tgt_inc = note_to_increment(s_tdata[6:0]);
                        if (stage == ENV_IDLE || g == 65536) cur_inc = tgt_inc;
                        glide = g;
                        stage = ENV_ATTACK;
                    end
                    msv_tb_pkg::REQ_NOTE_OFF: if (stage != ENV_IDLE) stage = ENV_RELEASE;
                    msv_tb_pkg::REQ_TICK:     sample_q.push_back(render_tick());
                    default: ;
                endcase
            end
        end
        pending_count = sample_q.size();
    end

endmodule

FILE: dv/tb_mono_synth_voice.sv
// Testbench top of the synth voice: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_mono_synth_voice;

    // A stalled run is one in which no channel moves a request for this many cycles.
    // The slowest tick plus a short result stall stays far below this limit, which
    // leaves a wide margin.
    localparam int STALL_LIMIT = 20000;
    // Cycles allowed after the last result before a register write, covering an
    // in-flight note request and the longest tick.
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_PHASES = 7;
    localparam int ITEMS_PER_PHASE = 200;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;     // [6:0] note_number, [23:7] glide_coeff
    logic [1:0]  s_tuser;     // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // [23:0] sample_out
    logic [0:0]  m_tuser;     // [0] voice_active
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    int error_count;
    int pending_count;
    int stall_cycles;
    // When set, neither side inserts idle cycles.
    bit quiet;

    mono_synth_voice u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    msv_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .error_count(error_count), .pending_count(pending_count)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The result side stalls about one cycle in ten unless idling is switched off.
    always @(negedge aclk) begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end

    // The watchdog restarts whenever any channel completes a request.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Presents one request at a falling edge and returns at the rising edge that
    // accepts it. The valid stays high so that back-to-back requests need no
    // second assignment in one step.
    task automatic send_request(msv_tb_pkg::req_kind_t kind, logic [6:0] note,
                                logic [16:0] glide);
        int gap;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 99) < 10) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {glide, note};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drops the request valid, waits for every expected sample and lets the
    // block finish any note request that produces no result.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(msv_tb_pkg::reg_index_t idx, logic [23:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [23:0] blend, logic [23:0] drive, logic [23:0] alpha,
                             logic [23:0] fb, logic [23:0] attack, logic [23:0] decay,
                             logic [23:0] sustain, logic [23:0] rel);
        write_register(msv_tb_pkg::REG_OSC_BLEND, blend);
        write_register(msv_tb_pkg::REG_DRIVE_AMOUNT, drive);
        write_register(msv_tb_pkg::REG_FILTER_ALPHA, alpha);
        write_register(msv_tb_pkg::REG_FILTER_FEEDBACK, fb);
        write_register(msv_tb_pkg::REG_ATTACK_STEP, attack);
        write_register(msv_tb_pkg::REG_DECAY_COEFF, decay);
        write_register(msv_tb_pkg::REG_SUSTAIN_LEVEL, sustain);
        write_register(msv_tb_pkg::REG_RELEASE_COEFF, rel);
    endtask

    // Half the glide values are real glides; the rest are exact jumps and
    // out-of-range jumps in equal parts.
    function automatic logic [16:0] pick_glide();
        case ($urandom_range(0, 3))
            0:       return 17'd65536;
            1:       return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_ticks(int n, inout int sent);
        for (int i = 0; i < n; i++) begin
            send_request(msv_tb_pkg::REQ_TICK, 7'd0, 17'($urandom_range(0, 131071)));
            sent++;
        end
    endtask

    // Most of the traffic is whole phrases: a note, sometimes a legato second
    // note that may glide, a release and its tail. The rest is loose requests.
    task automatic random_phase(int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 99) < 85) begin
                send_request(msv_tb_pkg::REQ_NOTE_ON, 7'($urandom_range(0, 127)),
                             pick_glide());
                send_ticks($urandom_range(1, 30), sent);
                if ($urandom_range(0, 2) == 0) begin
                    send_request(msv_tb_pkg::REQ_NOTE_ON, 7'($urandom_range(0, 127)),
                                 pick_glide());
                    send_ticks($urandom_range(1, 30), sent);
                end
                send_request(msv_tb_pkg::REQ_NOTE_OFF, 7'($urandom_range(0, 127)),
                             pick_glide());
                send_ticks($urandom_range(1, 30), sent);
            end else begin
                send_request(msv_tb_pkg::req_kind_t'($urandom_range(0, 3)),
                             7'($urandom_range(0, 127)), 17'($urandom_range(0, 131071)));
                sent++;
            end
        end
    endtask

    initial begin
        quiet     = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = msv_tb_pkg::REQ_TICK;
        cfg_valid = 1'b0;
        cfg_index = msv_tb_pkg::REG_OSC_BLEND;
        cfg_data  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part under the reset settings: idle ticks, the unused kind,
        // a note off while idle, the lowest and highest notes with the glide at
        // both extremes, a real glide and a release.
        send_request(msv_tb_pkg::REQ_TICK, 7'd0, 17'd0);
        send_request(msv_tb_pkg::REQ_UNUSED, 7'd127, 17'h1FFFF);
        send_request(msv_tb_pkg::REQ_NOTE_OFF, 7'd0, 17'd0);
        send_request(msv_tb_pkg::REQ_TICK, 7'd127, 17'h1FFFF);
        send_request(msv_tb_pkg::REQ_NOTE_ON, 7'd0, 17'd0);
        send_request(msv_tb_pkg::REQ_TICK, 7'd0, 17'd0);
        send_request(msv_tb_pkg::REQ_TICK, 7'd0, 17'd0);
        send_request(msv_tb_pkg::REQ_NOTE_ON, 7'd127, 17'h1FFFF);
        send_request(msv_tb_pkg::REQ_TICK, 7'd0, 17'd0);
        send_request(msv_tb_pkg::REQ_NOTE_ON, 7'd69, 17'd1000);
        for (int i = 0; i < 6; i++) send_request(msv_tb_pkg::REQ_TICK, 7'd0, 17'd0);
        send_request(msv_tb_pkg::REQ_NOTE_OFF, 7'd69, 17'd0);
        send_request(msv_tb_pkg::REQ_TICK, 7'd0, 17'd0);
        send_request(msv_tb_pkg::REQ_TICK, 7'd0, 17'd0);
        send_request(msv_tb_pkg::REQ_NOTE_ON, 7'd60, 17'd65536);
        send_request(msv_tb_pkg::REQ_TICK, 7'd0, 17'd0);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                // Upper extremes; out-of-range decay and sustain values saturate.
                0: write_all(24'd65535, 24'd65535, 24'd1, 24'd65535,
                             24'd8388608, 24'hFFFFFF, 24'hFFFFFF, 24'd65535);
                // Lower extremes with the clip bypassed and instant release.
                1: write_all(24'd0, 24'd0, 24'd65535, 24'd0, 24'd1, 24'd1, 24'd0, 24'd0);
                default: write_all(
                    24'($urandom_range(0, 65535)),
                    24'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 65535)),
                    24'($urandom_range(1, 65535)),
                    24'($urandom_range(0, 65535)),
                    24'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 8388608)
                                                    : $urandom_range(32768, 8388608)),
                    24'($urandom_range(1, 131071)),
                    24'($urandom_range(0, 16777215)),
                    24'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 60000)));
            endcase
            // One phase runs with no idling on either side.
            quiet = (p == 3);
            random_phase(ITEMS_PER_PHASE);
            settle();
        end

        if (error_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
